// ----- design/apjb_pkg.sv -----
// ----------------------------------------------------------------------------
// apjb_pkg: shared definitions for the audio playout jitter buffer
// ring geometry, field widths, register codes and reset values, ring index helpers
// ----------------------------------------------------------------------------
package apjb_pkg;

   // ring and chunk geometry
   localparam int RING_DEPTH = 32768;
   localparam int MAX_CHUNK  = 1024;

   localparam int IDX_W    = $clog2(RING_DEPTH);
   localparam int FILL_W   = $clog2(RING_DEPTH + 1);
   localparam int CHUNK_W  = $clog2(MAX_CHUNK + 1);

   // fixed field widths
   localparam int SAMPLE_W   = 16;
   localparam int LEVEL_W    = 16;
   localparam int CSR_DATA_W = 16;
   localparam int PREROLL_W  = 16;
   localparam int CAP_W      = 16;
   localparam int CLEN_W     = 11;

   // working widths for compares and ring arithmetic
   localparam int CMP_W   = (FILL_W > CAP_W) ? FILL_W : CAP_W;
   localparam int CLAMP_W = (CLEN_W > CHUNK_W) ? CLEN_W : CHUNK_W;
   localparam int ADD_W   = ((IDX_W > CHUNK_W) ? IDX_W : CHUNK_W) + 1;
   localparam int SUB_W   = FILL_W + 1;

   typedef logic [IDX_W-1:0]    ring_idx_type;
   typedef logic [FILL_W-1:0]   fill_type;
   typedef logic [CHUNK_W-1:0]  chunk_cnt_type;
   typedef logic [SAMPLE_W-1:0] sample_type;

   // configuration register indexes
   typedef enum logic [1:0] {
      CSR_OUTPUT_ENABLE = 2'd0,
      CSR_PREROLL_LEVEL = 2'd1,
      CSR_LATENCY_CAP   = 2'd2,
      CSR_CHUNK_LENGTH  = 2'd3
   } csr_index_type;

   // request codes
   typedef enum logic {
      REQ_PUSH = 1'b0,
      REQ_PULL = 1'b1
   } req_code_type;

   localparam logic                 RST_OUTPUT_ENABLE = 1'b1;
   localparam logic [PREROLL_W-1:0] RST_PREROLL_LEVEL = 16'd15876;
   localparam logic [CAP_W-1:0]     RST_LATENCY_CAP   = 16'd28224;
   localparam logic [CLEN_W-1:0]    RST_CHUNK_LENGTH  = 11'd704;

   // next ring position with wrap
   function automatic ring_idx_type ring_next(input ring_idx_type idx);
      logic [IDX_W:0] s;
      s = {1'b0, idx} + (IDX_W+1)'(1);
      if (s >= (IDX_W+1)'(RING_DEPTH)) begin
         s = '0;
      end
      return IDX_W'(s);
   endfunction

   // idx + n modulo ring depth, n never above the depth
   function automatic ring_idx_type ring_add(input ring_idx_type idx, input chunk_cnt_type n);
      logic [ADD_W-1:0] s;
      s = ADD_W'(idx) + ADD_W'(n);
      if (s >= ADD_W'(RING_DEPTH)) begin
         s = s - ADD_W'(RING_DEPTH);
      end
      return IDX_W'(s);
   endfunction

   // idx - n modulo ring depth, n never above the depth
   function automatic ring_idx_type ring_sub(input ring_idx_type idx, input fill_type n);
      logic [SUB_W-1:0] a;
      a = SUB_W'(idx);
      if (a < SUB_W'(n)) begin
         a = a + SUB_W'(RING_DEPTH);
      end
      a = a - SUB_W'(n);
      return IDX_W'(a);
   endfunction

endpackage

// ----- design/apjb_ram.sv -----
// ----------------------------------------------------------------------------
// apjb_ram: generic simple dual-port ram
// one write port, one read port, read data registered and held between reads
// ----------------------------------------------------------------------------
module apjb_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/audio_playout_jitter_buffer.sv -----
// ----------------------------------------------------------------------------
// audio_playout_jitter_buffer: playout ring for signed 16-bit pcm with preroll
// push words fill a sample ram, pull words drain it chunk by chunk with
// zero padding on underrun and a marker on the last word of each chunk
// ----------------------------------------------------------------------------
// result: a pull word gives its result in the cycle after acceptance (ram read)
// throughput: one request word per cycle while the result channel is not stalled,
//   pushes and pulls in any mix; the single ram write port and single read port each see at most one access
// reset: indices, fill, play state and chunk counters clear at once and the
//   registers take their defaults; sample ram contents are not cleared
// ----------------------------------------------------------------------------
module audio_playout_jitter_buffer
   import apjb_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,

   // request channel
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_type,
   input  logic [SAMPLE_W-1:0]   req_sample_value,
   input  logic                  req_burst_end,

   // result channel
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [SAMPLE_W-1:0]   rsp_out_sample,
   output logic                  rsp_is_padding,
   output logic                  rsp_chunk_last,
   output logic [LEVEL_W-1:0]    rsp_queued_level,

   // configuration write port
   input  logic                  csr_wr_en,
   input  logic [1:0]            csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data
);

   // configuration registers
   logic                 out_en_ff;
   logic [PREROLL_W-1:0] preroll_ff;
   logic [CAP_W-1:0]     cap_ff;
   logic [CLEN_W-1:0]    clen_ff;

   // ring state; read index plus fill always equals write index modulo depth
   ring_idx_type  wr_idx_ff,   wr_idx_in;
   ring_idx_type  rd_idx_ff,   rd_idx_in;
   fill_type      fill_ff,     fill_in;
   logic          playing_ff,  playing_in;
   ring_idx_type  chunk_idx_ff, chunk_idx_in;
   chunk_cnt_type real_left_ff, real_left_in;
   chunk_cnt_type pad_left_ff,  pad_left_in;

   // output register; sample itself sits in the ram read register
   logic               rsp_valid_ff,  rsp_valid_in;
   logic               rsp_pad_ff,    rsp_pad_in;
   logic               rsp_last_ff,   rsp_last_in;
   logic [LEVEL_W-1:0] rsp_level_ff,  rsp_level_in;

   // ram ports
   logic         ram_wr_en;
   logic         ram_rd_en;
   ring_idx_type ram_rd_addr;
   sample_type   ram_rd_data;

   logic accept;
   logic is_push;
   logic is_pull;

   // push arithmetic
   logic     ring_full;
   fill_type fill_grown;
   fill_type fill_pushed;

   // chunk start arithmetic
   logic          chunk_idle;
   logic          start_ok;
   chunk_cnt_type chunk_eff;
   chunk_cnt_type take;
   ring_idx_type  cur_chunk_idx;
   chunk_cnt_type cur_real;
   chunk_cnt_type cur_pad;
   fill_type      cur_fill;
   ring_idx_type  cur_rd_idx;

   // the output register frees up when empty or when taken this cycle
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign is_push   = accept && (req_type == REQ_PUSH) && out_en_ff;
   assign is_pull   = accept && (req_type == REQ_PULL);

   // ---------------------------------------------------------------------
   // configuration writes
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         out_en_ff  <= RST_OUTPUT_ENABLE;
         preroll_ff <= RST_PREROLL_LEVEL;
         cap_ff     <= RST_LATENCY_CAP;
         clen_ff    <= RST_CHUNK_LENGTH;
      end else if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_OUTPUT_ENABLE: out_en_ff  <= csr_wr_data[0];
            CSR_PREROLL_LEVEL: preroll_ff <= csr_wr_data[PREROLL_W-1:0];
            CSR_LATENCY_CAP:   cap_ff     <= csr_wr_data[CAP_W-1:0];
            CSR_CHUNK_LENGTH:  clen_ff    <= csr_wr_data[CLEN_W-1:0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // push: store, grow fill (a full ring drops its oldest word), then trim
   // to the latency cap; the read index follows from the write index
   // ---------------------------------------------------------------------
   always_comb begin
      ring_full  = (fill_ff >= FILL_W'(RING_DEPTH));
      fill_grown = ring_full ? fill_ff : fill_ff + FILL_W'(1);
      if (CMP_W'(fill_grown) > CMP_W'(cap_ff)) begin
         fill_pushed = FILL_W'(cap_ff);
      end else begin
         fill_pushed = fill_grown;
      end
   end

   // ---------------------------------------------------------------------
   // pull: at a chunk boundary reserve min(fill, chunk) words, rest is pad
   // ---------------------------------------------------------------------
   always_comb begin
      chunk_idle = (real_left_ff == '0) && (pad_left_ff == '0);

      // chunk length of zero counts as one, anything above the maximum saturates
      if (clen_ff == '0) begin
         chunk_eff = CHUNK_W'(1);
      end else if (CLAMP_W'(clen_ff) > CLAMP_W'(MAX_CHUNK)) begin
         chunk_eff = CHUNK_W'(MAX_CHUNK);
      end else begin
         chunk_eff = CHUNK_W'(clen_ff);
      end

      start_ok = playing_ff || (CMP_W'(fill_ff) >= CMP_W'(preroll_ff));

      if (CMP_W'(fill_ff) < CMP_W'(chunk_eff)) begin
         take = CHUNK_W'(fill_ff);
      end else begin
         take = chunk_eff;
      end

      if (chunk_idle) begin
         cur_chunk_idx = rd_idx_ff;
         cur_real      = take;
         cur_pad       = chunk_eff - take;
         cur_fill      = fill_ff - FILL_W'(take);
         cur_rd_idx    = ring_add(rd_idx_ff, take);
      end else begin
         cur_chunk_idx = chunk_idx_ff;
         cur_real      = real_left_ff;
         cur_pad       = pad_left_ff;
         cur_fill      = fill_ff;
         cur_rd_idx    = rd_idx_ff;
      end
   end

   // ---------------------------------------------------------------------
   // next state
   // ---------------------------------------------------------------------
   always_comb begin
      wr_idx_in    = wr_idx_ff;
      rd_idx_in    = rd_idx_ff;
      fill_in      = fill_ff;
      playing_in   = playing_ff;
      chunk_idx_in = chunk_idx_ff;
      real_left_in = real_left_ff;
      pad_left_in  = pad_left_ff;

      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_pad_in   = rsp_pad_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_level_in = rsp_level_ff;

      ram_rd_en   = 1'b0;
      ram_rd_addr = cur_chunk_idx;

      if (is_push) begin
         wr_idx_in = ring_next(wr_idx_ff);
         fill_in   = fill_pushed;
         rd_idx_in = ring_sub(ring_next(wr_idx_ff), fill_pushed);
      end else if (is_pull && start_ok) begin
         // a pull before playback starts, with fill below the preroll level, leaves everything as it was
         playing_in = 1'b1;
         rd_idx_in  = cur_rd_idx;
         fill_in    = cur_fill;
         if (cur_real != '0) begin
            ram_rd_en    = 1'b1;
            chunk_idx_in = ring_next(cur_chunk_idx);
            real_left_in = cur_real - CHUNK_W'(1);
            pad_left_in  = cur_pad;
            rsp_pad_in   = 1'b0;
         end else begin
            chunk_idx_in = cur_chunk_idx;
            real_left_in = cur_real;
            pad_left_in  = cur_pad - CHUNK_W'(1);
            rsp_pad_in   = 1'b1;
         end
         rsp_valid_in = 1'b1;
         rsp_last_in  = (real_left_in == '0) && (pad_left_in == '0);
         rsp_level_in = LEVEL_W'(cur_fill);
      end
   end

   assign ram_wr_en = is_push;

   // ---------------------------------------------------------------------
   // state registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_idx_ff    <= '0;
         rd_idx_ff    <= '0;
         fill_ff      <= '0;
         playing_ff   <= 1'b0;
         chunk_idx_ff <= '0;
         real_left_ff <= '0;
         pad_left_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         wr_idx_ff    <= wr_idx_in;
         rd_idx_ff    <= rd_idx_in;
         fill_ff      <= fill_in;
         playing_ff   <= playing_in;
         chunk_idx_ff <= chunk_idx_in;
         real_left_ff <= real_left_in;
         pad_left_ff  <= pad_left_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload, no reset needed
   always_ff @(posedge clock) begin
      rsp_pad_ff   <= rsp_pad_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_level_ff <= rsp_level_in;
   end

   // ---------------------------------------------------------------------
   // sample ram; burst_end carries no behaviour and is not stored
   // ---------------------------------------------------------------------
   apjb_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (RING_DEPTH)
   ) u_sample_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (wr_idx_ff),
      .wr_data (req_sample_value),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // the ram read register holds while the result waits, so it acts as the
   // sample half of the output register
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_sample   = rsp_pad_ff ? '0 : ram_rd_data;
   assign rsp_is_padding   = rsp_pad_ff;
   assign rsp_chunk_last   = rsp_last_ff;
   assign rsp_queued_level = rsp_level_ff;

endmodule
